// File: hdl/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared constants, widths and controller/datapath interface types of the
// pulse beat rate detector.
// ----------------------------------------------------------------------------
package pbrd_pkg;

    localparam int SAMPLE_WINDOW  = 10;
    localparam int BEAT_WINDOW    = 10;
    localparam int SAMPLE_BITS    = 12;

    localparam int SAMPLE_FIELD_W = 12;
    localparam int THRESHOLD_W    = 12;
    localparam int TIME_W         = 32;
    localparam int RATE_W         = 20;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 12'd3000;
    localparam int RATE_NUMERATOR = 9 * 1000 * 60;

    // The window sum stays below SAMPLE_WINDOW * 2^SAMPLE_BITS.
    localparam int SUM_W     = SAMPLE_BITS + $clog2(SAMPLE_WINDOW);
    localparam int DIV_W     = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // The mean is the sum times the rounded-up reciprocal of SAMPLE_WINDOW.
    // The extra shift bits keep the truncated quotient exact for every sum.
    localparam int MEAN_SHIFT  = SUM_W + $clog2(SAMPLE_WINDOW);
    localparam int MEAN_MULT   = ((1 << MEAN_SHIFT) + SAMPLE_WINDOW - 1) / SAMPLE_WINDOW;
    localparam int MEAN_MULT_W = $clog2(MEAN_MULT + 1);
    localparam int MEAN_PROD_W = SUM_W + MEAN_MULT_W;

    localparam int SHEAD_W = $clog2(SAMPLE_WINDOW);
    localparam int SCNT_W  = $clog2(SAMPLE_WINDOW + 1);
    localparam int BHEAD_W = $clog2(BEAT_WINDOW);
    localparam int BCNT_W  = $clog2(BEAT_WINDOW + 1);

    localparam int SMP_EXT_W = (SAMPLE_FIELD_W > SAMPLE_BITS) ? SAMPLE_FIELD_W : SAMPLE_BITS;
    localparam int CMP_W     = (SAMPLE_BITS > THRESHOLD_W) ? SAMPLE_BITS : THRESHOLD_W;

    localparam int IN_DATA_W  = ((SAMPLE_FIELD_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + RATE_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;        // capture the input beat, read the oldest sample
        logic sum_upd;     // write the sample window and update the running sum
        logic avg_load;    // register the window mean
        logic avg_eval;    // take the mean, test the crossing, record a beat
        logic rate_start;  // start the divider on numerator / span
        logic rate_load;   // take the new rate from the divider
        logic out_load;    // move the result into the output register
    } pbrd_cmd_t;

    typedef struct packed {
        logic full;        // sample window holds SAMPLE_WINDOW samples
        logic div_done;    // divider quotient is ready
        logic beat_hit;    // mean crosses the threshold upward
        logic beat_full;   // beat window holds BEAT_WINDOW times
        logic span_zero;   // newest and oldest beat times are equal
        logic out_free;    // output register can take a result
    } pbrd_status_t;

endpackage

// File: hdl/pbrd_div.sv
// ----------------------------------------------------------------------------
// pbrd_div
// Restoring divider, one quotient bit per cycle, used for the rate
// computation.
// ----------------------------------------------------------------------------
module pbrd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pbrd_pkg::DIV_W-1:0]  dividend,
    input  logic [pbrd_pkg::TIME_W-1:0] divisor,
    output logic                       done,
    output logic [pbrd_pkg::DIV_W-1:0]  quotient
);
    import pbrd_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [TIME_W:0]      rem_shift;
    logic [TIME_W:0]      rem_diff;
    logic                 fits;
    logic [TIME_W-1:0]    rem_next;
    logic [DIV_W-1:0]     quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = fits ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
        quo_next  = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/pbrd_ctrl.sv
// ----------------------------------------------------------------------------
// pbrd_ctrl
// Controller state machine: sequences one sample through window update,
// mean, crossing test, beat record, rate division and result hand-off.
// ----------------------------------------------------------------------------
module pbrd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  pbrd_pkg::pbrd_status_t status,
    output pbrd_pkg::pbrd_cmd_t    cmd
);
    import pbrd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_TEST,
        ST_SPAN,
        ST_RATE_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_upd = 1'b1;
                state_next  = status.full ? ST_MEAN : ST_OUT;
            end
            ST_MEAN:
            begin
                cmd.avg_load = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.avg_eval = 1'b1;
                state_next   = (status.beat_hit && status.beat_full) ? ST_SPAN : ST_OUT;
            end
            ST_SPAN:
            begin
                // A zero span leaves the rate as it was.
                cmd.rate_start = !status.span_zero;
                state_next     = status.span_zero ? ST_OUT : ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.rate_load = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: hdl/pbrd_dp.sv
// ----------------------------------------------------------------------------
// pbrd_dp
// Datapath: sample window with running sum, reciprocal-multiply mean, beat
// time window, threshold register, rate divider and the output register.
// ----------------------------------------------------------------------------
module pbrd_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pbrd_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pbrd_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 threshold_we,
    input  logic [pbrd_pkg::THRESHOLD_W-1:0]     threshold_data,
    input  pbrd_pkg::pbrd_cmd_t                  cmd,
    output pbrd_pkg::pbrd_status_t               status
);
    import pbrd_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_mem [SAMPLE_WINDOW];
    logic [TIME_W-1:0]      beat_mem   [BEAT_WINDOW];

    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [SHEAD_W-1:0]     shead_reg;
    logic [SCNT_W-1:0]      scnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] prev_avg_reg;
    logic [BHEAD_W-1:0]     bhead_reg;
    logic [BCNT_W-1:0]      bcnt_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic                   beat_reg;
    logic                   m_tvalid_reg;

    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [TIME_W-1:0]      time_reg;
    logic [SAMPLE_BITS-1:0] smp_rd_reg;
    logic [TIME_W-1:0]      beat_rd_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic                   beat_out_reg;
    logic [RATE_W-1:0]      rate_out_reg;

    logic [SMP_EXT_W-1:0]   smp_ext;
    logic                   full;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_next;
    logic [SHEAD_W-1:0]     shead_next;
    logic [BHEAD_W-1:0]     bhead_next;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic                   beat_hit;
    logic                   beat_full;
    logic [TIME_W-1:0]      span;

    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [TIME_W-1:0]      div_divisor;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quotient;

    always_comb
    begin
        smp_ext    = SMP_EXT_W'(s_tdata[SAMPLE_FIELD_W-1:0]);
        full       = (scnt_reg == SCNT_W'(SAMPLE_WINDOW));
        // The oldest sample leaves the sum only once the window is full.
        sum_wide   = ({1'b0, sum_reg} + (SUM_W + 1)'(smp_reg))
                     - (full ? (SUM_W + 1)'(smp_rd_reg) : '0);
        sum_next   = sum_wide[SUM_W-1:0];
        shead_next = (shead_reg == SHEAD_W'(SAMPLE_WINDOW - 1)) ? '0 : shead_reg + 1'b1;
        bhead_next = (bhead_reg == BHEAD_W'(BEAT_WINDOW - 1)) ? '0 : bhead_reg + 1'b1;
        mean_prod  = MEAN_PROD_W'(sum_reg) * MEAN_PROD_W'(MEAN_MULT);
        beat_hit   = (CMP_W'(avg_reg) > CMP_W'(threshold_reg))
                     && (CMP_W'(prev_avg_reg) < CMP_W'(threshold_reg));
        beat_full  = (bcnt_reg == BCNT_W'(BEAT_WINDOW));
        span       = time_reg - beat_rd_reg;

        div_start    = cmd.rate_start;
        div_dividend = DIV_W'(RATE_NUMERATOR);
        div_divisor  = span;
    end

    pbrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            shead_reg     <= '0;
            scnt_reg      <= '0;
            sum_reg       <= '0;
            prev_avg_reg  <= '0;
            bhead_reg     <= '0;
            bcnt_reg      <= '0;
            rate_reg      <= '0;
            beat_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (threshold_we)
            begin
                threshold_reg <= threshold_data;
            end
            if (cmd.load)
            begin
                beat_reg <= 1'b0;
            end
            if (cmd.sum_upd)
            begin
                sum_reg   <= sum_next;
                shead_reg <= shead_next;
                if (!full)
                begin
                    scnt_reg <= scnt_reg + 1'b1;
                end
            end
            if (cmd.avg_eval)
            begin
                prev_avg_reg <= avg_reg;
                if (beat_hit)
                begin
                    beat_reg  <= 1'b1;
                    bhead_reg <= bhead_next;
                    if (!beat_full)
                    begin
                        bcnt_reg <= bcnt_reg + 1'b1;
                    end
                end
            end
            if (cmd.rate_load)
            begin
                rate_reg <= div_quotient[RATE_W-1:0];
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the two window memories.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg    <= smp_ext[SAMPLE_BITS-1:0];
            time_reg   <= s_tdata[SAMPLE_FIELD_W +: TIME_W];
            smp_rd_reg <= sample_mem[shead_reg];
        end
        if (cmd.sum_upd)
        begin
            sample_mem[shead_reg] <= smp_reg;
        end
        if (cmd.avg_load)
        begin
            avg_reg <= mean_prod[MEAN_SHIFT +: SAMPLE_BITS];
        end
        if (cmd.avg_eval && beat_hit)
        begin
            // After the write the next slot holds the oldest beat time.
            beat_mem[bhead_reg] <= time_reg;
            beat_rd_reg         <= beat_mem[bhead_next];
        end
        if (cmd.out_load)
        begin
            beat_out_reg <= beat_reg;
            rate_out_reg <= rate_reg;
        end
    end

    always_comb
    begin
        status.full      = full;
        status.div_done  = div_done;
        status.beat_hit  = beat_hit;
        status.beat_full = beat_full;
        status.span_zero = (span == '0);
        status.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({rate_out_reg, beat_out_reg});

endmodule

// File: hdl/pulse_beat_rate_detector_core.sv
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector_core
// Pulse sensor beat detector: moving average of the last samples, upward
// threshold crossing, and beats per minute from a window of beat times.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake              Payload
// s_*         in         s_tvalid / s_tready    sample [11:0], time_ms [43:12]
// m_*         out        m_tvalid / m_tready    beat [0], rate_bpm [20:1]
// threshold_* in         threshold_we           threshold [11:0]
//
// One sample is processed at a time. Each sample passes ST_IDLE and ST_SUM and
// goes straight to ST_OUT while the sample window fills; otherwise it passes
// ST_MEAN and ST_TEST, and a beat with a full beat window adds ST_SPAN and, for
// a nonzero span, ST_RATE_WAIT; the one-bit-per-cycle rate divider makes the
// rate update the longest path.
// Reset clears counts, the running sum, the previous mean and the rate; the
// window memories need no clearing pass.
// The result waits in an output register, so the next sample is taken while
// the consumer stalls; a finished sample waits only if that register is full.
module pulse_beat_rate_detector_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields from bit 0: sample [11:0], time_ms [43:12], zero pad
    input  logic [pbrd_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata fields from bit 0: beat [0], rate_bpm [20:1], zero pad
    output logic [pbrd_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 threshold_we,
    input  logic [pbrd_pkg::THRESHOLD_W-1:0]     threshold_data
);
    import pbrd_pkg::*;

    pbrd_cmd_t    cmd;
    pbrd_status_t status;

    pbrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbrd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .threshold_we   (threshold_we),
        .threshold_data (threshold_data),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// File: hdl/pbrd_checker.sv
// ----------------------------------------------------------------------------
// pbrd_checker
// Port-level checks of the pulse beat rate detector, bound to the top level.
// ----------------------------------------------------------------------------
module pbrd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [pbrd_pkg::IN_DATA_W-1:0]       s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [pbrd_pkg::OUT_DATA_W-1:0]      m_tdata,
    input logic                                 threshold_we,
    input logic [pbrd_pkg::THRESHOLD_W-1:0]     threshold_data
);
    import pbrd_pkg::*;

    // A stalled result beat holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // One sample at a time: no input beat in the cycle after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in work");

    // A result never appears in the cycle right after its sample is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result shown before the sample was processed");

    // The rate can never exceed the numerator of the division.
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RATE_W:1] <= RATE_W'(RATE_NUMERATOR)))
        else $error("rate out of range");

endmodule

bind pulse_beat_rate_detector_core pbrd_checker u_pbrd_checker (.*);
